// ===== hdl/ieqrc_pkg.sv =====
// Shared types, constants and pointer helpers for the input event queue.
// Used by the controller, the datapath and the top level.
package ieqrc_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] EV_SYN       = 16'd0;
    localparam logic [15:0] CODE_REPORT  = 16'd0;
    localparam logic [15:0] CODE_DROPPED = 16'd3;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_FILT = 2'd2,
        MODE_NOP  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_DROP      = 4'd1,
        OP_PUSH      = 4'd2,
        OP_STAMP_WR  = 4'd3,
        OP_STAMP_END = 4'd4,
        OP_POP_RD    = 4'd5,
        OP_POP_CAP   = 4'd6,
        OP_FINIT     = 4'd7,
        OP_FILT_RD   = 4'd8,
        OP_FILT_WR   = 4'd9,
        OP_FEND      = 4'd10,
        OP_RES_LOAD  = 4'd11
    } t_op;

    typedef struct packed {
        logic in_ready;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic  in_valid;
        t_mode mode;
        logic  full;
        logic  is_report;
        logic  walk_done;
        logic  empty;
        logic  scan_done;
        logic  out_free;
    } t_sts;

    function automatic t_ptr ptr_inc(input t_ptr p);
        if (p == t_ptr'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + t_ptr'(1);
    endfunction

    function automatic t_ptr ptr_dec(input t_ptr p);
        if (p == '0) begin
            return t_ptr'(QUEUE_DEPTH - 1);
        end
        return p - t_ptr'(1);
    endfunction

endpackage

// ===== hdl/ieqrc_in_if.sv =====
// Request channel of the event queue: valid/ready plus one command beat.
// No dependencies.
interface ieqrc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
    logic [63:0]        stamp;

    modport source (output valid, mode, ev_type, ev_code, ev_value, stamp, input ready);
    modport sink   (input valid, mode, ev_type, ev_code, ev_value, stamp, output ready);
endinterface

// ===== hdl/ieqrc_out_if.sv =====
// Result channel of the event queue: valid/ready plus one result beat.
// No dependencies.
interface ieqrc_out_if;
    logic               valid;
    logic               ready;
    logic               out_valid;
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic [63:0]        out_stamp;
    logic               queue_empty;
    logic               overflowed;

    modport source (output valid, out_valid, out_type, out_code, out_value, out_stamp,
                    queue_empty, overflowed, input ready);
    modport sink   (input valid, out_valid, out_type, out_code, out_value, out_stamp,
                    queue_empty, overflowed, output ready);
endinterface

// ===== hdl/ieqrc_ctrl.sv =====
// Sequencer of the event queue: one-hot state machine issuing datapath commands.
// Depends on ieqrc_pkg.
module ieqrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ieqrc_pkg::t_sts i_sts,
    output ieqrc_pkg::t_cmd o_cmd
);
    import ieqrc_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_DISP    = 13'b0000000000010,
        S_DROP    = 13'b0000000000100,
        S_PUSH    = 13'b0000000001000,
        S_STAMP   = 13'b0000000010000,
        S_POP_RD  = 13'b0000000100000,
        S_POP_CAP = 13'b0000001000000,
        S_FINIT   = 13'b0000010000000,
        S_FCHK    = 13'b0000100000000,
        S_FRD     = 13'b0001000000000,
        S_FWR     = 13'b0010000000000,
        S_FEND    = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.in_ready  = 1'b0;
        o_cmd.op        = OP_NOP;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.mode)
                    MODE_PUSH: n_state = i_sts.full ? S_DROP : S_PUSH;
                    MODE_POP:  n_state = i_sts.empty ? S_DONE : S_POP_RD;
                    MODE_FILT: n_state = S_FINIT;
                    default:   n_state = S_DONE;
                endcase
            end
            S_DROP: begin
                o_cmd.op = OP_DROP;
                n_state  = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.op = OP_PUSH;
                n_state  = i_sts.is_report ? S_STAMP : S_DONE;
            end
            S_STAMP: begin
                // Walk from the commit point up to the new tail, then commit.
                if (i_sts.walk_done) begin
                    o_cmd.op = OP_STAMP_END;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_STAMP_WR;
                end
            end
            S_POP_RD: begin
                o_cmd.op = OP_POP_RD;
                n_state  = S_POP_CAP;
            end
            S_POP_CAP: begin
                o_cmd.op = OP_POP_CAP;
                n_state  = S_DONE;
            end
            S_FINIT: begin
                o_cmd.op = OP_FINIT;
                n_state  = S_FCHK;
            end
            S_FCHK: begin
                n_state = i_sts.scan_done ? S_FEND : S_FRD;
            end
            S_FRD: begin
                o_cmd.op = OP_FILT_RD;
                n_state  = S_FWR;
            end
            S_FWR: begin
                o_cmd.op = OP_FILT_WR;
                n_state  = S_FCHK;
            end
            S_FEND: begin
                o_cmd.op = OP_FEND;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_RES_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ieqrc_dp.sv =====
// Datapath of the event queue: event memory, ring pointers, input and result registers.
// Depends on ieqrc_pkg, ieqrc_in_if and ieqrc_out_if.
module ieqrc_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ieqrc_pkg::t_cmd i_cmd,
    output ieqrc_pkg::t_sts o_sts,
    ieqrc_in_if.sink        i_in,
    ieqrc_out_if.source     o_out
);
    import ieqrc_pkg::*;

    // Payload word: type in [63:48], code in [47:32], value in [31:0].
    logic [63:0] r_mem_pay [QUEUE_DEPTH];
    logic [63:0] r_mem_stm [QUEUE_DEPTH];

    t_ptr r_rp, r_wp, r_cp, r_walk, r_end, r_tp;
    logic r_last_rep;

    t_mode              r_mode;
    logic [15:0]        r_type;
    logic [15:0]        r_code;
    logic signed [31:0] r_value;
    logic [63:0]        r_stamp;
    logic               r_ovf;

    logic [63:0] r_rd_pay, r_rd_stm;

    logic        r_res_vld;
    logic [63:0] r_res_pay, r_res_stm;

    logic               r_out_vld;
    logic               r_out_ok;
    logic [15:0]        r_out_type;
    logic [15:0]        r_out_code;
    logic signed [31:0] r_out_value;
    logic [63:0]        r_out_stamp;
    logic               r_out_empty;
    logic               r_out_ovf;

    logic        ld_in;
    logic        we_pay, we_stm, re;
    t_ptr        wa, ra;
    logic [63:0] wd_pay, wd_stm;
    logic        rd_rep, keep;

    assign ld_in       = i_in.valid & i_cmd.in_ready;
    assign i_in.ready  = i_cmd.in_ready;

    assign rd_rep = (r_rd_pay[63:48] == EV_SYN) && (r_rd_pay[47:32] == CODE_REPORT);
    // A kept entry is neither of the removed type nor a repeated report end.
    assign keep   = (r_rd_pay[63:48] != r_type) && !(rd_rep && r_last_rep);

    always_comb begin
        we_pay = 1'b0;
        we_stm = 1'b0;
        re     = 1'b0;
        wa     = r_wp;
        ra     = r_rp;
        wd_pay = {r_type, r_code, r_value};
        wd_stm = r_stamp;
        case (i_cmd.op)
            OP_DROP: begin
                we_pay = 1'b1;
                we_stm = 1'b1;
                wa     = ptr_dec(r_wp);
                wd_pay = {EV_SYN, CODE_DROPPED, 32'd0};
                wd_stm = 64'd0;
            end
            OP_PUSH: begin
                we_pay = 1'b1;
            end
            OP_STAMP_WR: begin
                we_stm = 1'b1;
                wa     = r_walk;
            end
            OP_POP_RD: begin
                re = 1'b1;
            end
            OP_FILT_RD: begin
                re = 1'b1;
                ra = r_walk;
            end
            OP_FILT_WR: begin
                we_pay = keep;
                we_stm = keep;
                wa     = r_tp;
                wd_pay = r_rd_pay;
                wd_stm = r_rd_stm;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_pay) begin
            r_mem_pay[wa] <= wd_pay;
        end
        if (we_stm) begin
            r_mem_stm[wa] <= wd_stm;
        end
        if (re) begin
            r_rd_pay <= r_mem_pay[ra];
            r_rd_stm <= r_mem_stm[ra];
        end
    end

    // Ring pointers and walk state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp       <= '0;
            r_wp       <= '0;
            r_cp       <= '0;
            r_walk     <= '0;
            r_end      <= '0;
            r_tp       <= '0;
            r_last_rep <= 1'b0;
            r_ovf      <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            if (ld_in) begin
                r_ovf     <= 1'b0;
                r_res_vld <= 1'b0;
            end
            case (i_cmd.op)
                OP_DROP: begin
                    r_rp  <= ptr_dec(r_wp);
                    r_cp  <= ptr_dec(r_wp);
                    r_ovf <= 1'b1;
                end
                OP_PUSH: begin
                    r_wp   <= ptr_inc(r_wp);
                    r_walk <= r_cp;
                end
                OP_STAMP_WR: begin
                    r_walk <= ptr_inc(r_walk);
                end
                OP_STAMP_END: begin
                    r_cp <= r_wp;
                end
                OP_POP_CAP: begin
                    r_res_vld <= 1'b1;
                    r_rp      <= ptr_inc(r_rp);
                end
                OP_FINIT: begin
                    r_walk     <= r_rp;
                    r_end      <= r_wp;
                    r_tp       <= r_wp;
                    r_cp       <= r_wp;
                    r_last_rep <= 1'b0;
                end
                OP_FILT_RD: begin
                    r_walk <= ptr_inc(r_walk);
                end
                OP_FILT_WR: begin
                    if (keep) begin
                        r_tp       <= ptr_inc(r_tp);
                        r_last_rep <= rd_rep;
                        if (rd_rep) begin
                            r_cp <= ptr_inc(r_tp);
                        end
                    end
                end
                OP_FEND: begin
                    r_rp <= r_walk;
                    r_wp <= r_tp;
                end
                default: begin
                end
            endcase
        end
    end

    // Captured request and popped event.
    always_ff @(posedge i_clk) begin
        if (ld_in) begin
            r_mode    <= t_mode'(i_in.mode);
            r_type    <= i_in.ev_type;
            r_code    <= i_in.ev_code;
            r_value   <= i_in.ev_value;
            r_stamp   <= i_in.stamp;
            r_res_pay <= 64'd0;
            r_res_stm <= 64'd0;
        end else if (i_cmd.op == OP_POP_CAP) begin
            r_res_pay <= r_rd_pay;
            r_res_stm <= r_rd_stm;
        end
    end

    // Output register: holds a finished beat while the next request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.op == OP_RES_LOAD) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RES_LOAD) begin
            r_out_ok    <= r_res_vld;
            r_out_type  <= r_res_pay[63:48];
            r_out_code  <= r_res_pay[47:32];
            r_out_value <= r_res_pay[31:0];
            r_out_stamp <= r_res_stm;
            r_out_empty <= (r_rp == r_cp);
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.out_valid   = r_out_ok;
    assign o_out.out_type    = r_out_type;
    assign o_out.out_code    = r_out_code;
    assign o_out.out_value   = r_out_value;
    assign o_out.out_stamp   = r_out_stamp;
    assign o_out.queue_empty = r_out_empty;
    assign o_out.overflowed  = r_out_ovf;

    assign o_sts.in_valid  = i_in.valid;
    assign o_sts.mode      = r_mode;
    assign o_sts.full      = (ptr_inc(r_wp) == r_rp);
    assign o_sts.is_report = (r_type == EV_SYN) && (r_code == CODE_REPORT);
    assign o_sts.walk_done = (r_walk == r_wp);
    assign o_sts.empty     = (r_rp == r_cp);
    assign o_sts.scan_done = (r_walk == r_end);
    assign o_sts.out_free  = !r_out_vld || o_out.ready;

`ifndef SYNTH
    // A pop read is only issued when a committed event exists.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_POP_RD) |-> (r_rp != r_cp))
        else $error("pop read issued on an empty queue");

    // The event write never lands on a full ring; the drop marker comes first.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_PUSH) |-> (ptr_inc(r_wp) != r_rp))
        else $error("push written into a full ring");

    // A result beat is never overwritten before it has been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_RES_LOAD) |-> (!r_out_vld || o_out.ready))
        else $error("result register overwritten while stalled");

    // A new request is taken only after the previous result was staged.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_in |=> (i_cmd.op != OP_RES_LOAD))
        else $error("result loaded in the cycle after a request was taken");
`endif

endmodule

// ===== hdl/input_event_queue_with_report_commit_unit.sv =====
// Top level of the input event queue with report commit.
// Depends on ieqrc_pkg, ieqrc_in_if, ieqrc_out_if, ieqrc_ctrl and ieqrc_dp.
//
//   Channel  Dir  Beat contents
//   i_in     in   mode, ev_type, ev_code, ev_value, stamp
//   o_out    out  out_valid, out_type, out_code, out_value, out_stamp, queue_empty, overflowed
//
// One request is worked at a time by the sequencer; the result register lets the
// next request in while a result beat waits. A pop reads the event memory and then
// captures the event, and skips both when empty; a push that meets a full ring first
// writes a drop marker, and a push that closes a report then stamps every event since
// the commit point; a filter reads each queued event once and writes back each kept one.
// Reset is synchronous, active low; the event memory is not cleared. A stalled result
// blocks only the request after the next one.
module input_event_queue_with_report_commit_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ieqrc_in_if.sink     i_in,
    ieqrc_out_if.source  o_out
);
    import ieqrc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ieqrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ieqrc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the input event queue with report commit: directed and random
// requests with a self-contained queue predictor and a result checker.
// Depends on ieqrc_pkg, ieqrc_in_if, ieqrc_out_if and the top level of the block.
`timescale 1ns / 100ps

module tb;
    import ieqrc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 250;

    typedef struct packed {
        logic [15:0] typ;
        logic [15:0] code;
        logic [31:0] value;
        logic [63:0] stamp;
    } t_ev_slot;

    typedef struct packed {
        logic        vld;
        logic [15:0] typ;
        logic [15:0] code;
        logic [31:0] value;
        logic [63:0] stamp;
        logic        empty;
        logic        ovf;
    } t_ev_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ieqrc_in_if  req_ch ();
    ieqrc_out_if rsp_ch ();

    input_event_queue_with_report_commit_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted queue contents and pointers.
    t_ev_slot   ring [QUEUE_DEPTH];
    t_ptr       rd_p = '0;
    t_ptr       wr_p = '0;
    t_ptr       cm_p = '0;
    t_ev_result expected_results [$];

    bit quiet = 1'b0;
    int n_items = 0;
    int n_popped = 0;
    int n_overflows = 0;
    int n_filters = 0;
    int n_reports = 0;
    int n_mismatches = 0;
    int n_cycles = 0;

    function automatic t_ptr ring_next(input t_ptr p);
        return t_ptr'((int'(p) + 1) % QUEUE_DEPTH);
    endfunction

    function automatic bit is_report_end(input t_ev_slot s);
        return s.typ == EV_SYN && s.code == CODE_REPORT;
    endfunction

    function automatic t_ev_result queue_step(input t_mode m, input logic [15:0] typ, code,
                                              input logic [31:0] value,
                                              input logic [63:0] stamp);
        t_ev_result r;
        t_ev_slot   e;
        t_ptr       p, marker, src, dst, stop;
        bit         prev_report;
        r = '0;
        case (m)
            MODE_PUSH: begin
                p = wr_p;
                if (ring_next(p) == rd_p) begin
                    // Full: everything queued is dropped and a marker takes the slot
                    // just behind the write position.
                    marker = t_ptr'((int'(p) + QUEUE_DEPTH - 1) % QUEUE_DEPTH);
                    ring[marker] = '{EV_SYN, CODE_DROPPED, 32'd0, 64'd0};
                    rd_p = marker;
                    cm_p = marker;
                    r.ovf = 1'b1;
                    n_overflows++;
                end
                ring[p].typ   = typ;
                ring[p].code  = code;
                ring[p].value = value;
                wr_p = ring_next(p);
                if (is_report_end(ring[p])) begin
                    for (src = cm_p; src != wr_p; src = ring_next(src)) begin
                        ring[src].stamp = stamp;
                    end
                    cm_p = wr_p;
                    n_reports++;
                end
            end
            MODE_POP: begin
                if (rd_p != cm_p) begin
                    r.vld   = 1'b1;
                    r.typ   = ring[rd_p].typ;
                    r.code  = ring[rd_p].code;
                    r.value = ring[rd_p].value;
                    r.stamp = ring[rd_p].stamp;
                    rd_p = ring_next(rd_p);
                    n_popped++;
                end
            end
            MODE_FILT: begin
                src = rd_p;
                stop = wr_p;
                dst = wr_p;
                prev_report = 1'b0;
                cm_p = stop;
                while (src != stop) begin
                    e = ring[src];
                    src = ring_next(src);
                    if (e.typ == typ) continue;
                    if (is_report_end(e)) begin
                        if (prev_report) continue;
                        cm_p = ring_next(dst);
                    end
                    ring[dst] = e;
                    prev_report = is_report_end(e);
                    dst = ring_next(dst);
                end
                rd_p = src;
                wr_p = dst;
                n_filters++;
            end
            default: ;
        endcase
        r.empty = (rd_p == cm_p);
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly a few small types so that filters hit, sometimes any type.
    function automatic logic [15:0] pick_type();
        case ($urandom_range(7))
            0, 1:    return EV_SYN;
            7:       return 16'($urandom);
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    task automatic send_request(input t_mode m, input logic [15:0] typ, code,
                                input logic [31:0] value, input logic [63:0] stamp);
        while (!quiet && $urandom_range(99) < 7) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= m;
        req_ch.ev_type  <= typ;
        req_ch.ev_code  <= code;
        req_ch.ev_value <= value;
        req_ch.stamp    <= stamp;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_results.push_back(queue_step(m, typ, code, value, stamp));
        n_items++;
    endtask

    task automatic push_event(input logic [15:0] typ, code, input logic [31:0] value);
        send_request(MODE_PUSH, typ, code, value, rand64());
    endtask

    task automatic push_report(input logic [63:0] stamp);
        send_request(MODE_PUSH, EV_SYN, CODE_REPORT, $urandom, stamp);
    endtask

    task automatic pop_event();
        send_request(MODE_POP, 16'($urandom), 16'($urandom), $urandom, rand64());
    endtask

    task automatic filter_type(input logic [15:0] typ);
        send_request(MODE_FILT, typ, 16'($urandom), $urandom, rand64());
    endtask

    // Any event except a report end.
    task automatic push_random_event();
        logic [15:0] typ;
        logic [15:0] code;
        typ = pick_type();
        code = 16'($urandom);
        if (typ == EV_SYN) begin
            code = ($urandom_range(1) != 0) ? CODE_DROPPED : 16'($urandom_range(1, 65535));
        end
        push_event(typ, code, $urandom);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic test_empty_and_nop();
        pop_event();
        send_request(MODE_NOP, 16'($urandom), 16'($urandom), $urandom, rand64());
    endtask

    task automatic test_report_commit();
        push_event(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
        push_event(16'h0001, 16'h0000, 32'h8000_0000);
        pop_event();
        push_report(64'hFFFF_FFFF_FFFF_FFFF);
        push_report(64'h0);
        repeat (5) pop_event();
    endtask

    task automatic test_filter();
        push_event(16'd3, 16'd1, 32'd5);
        push_report(rand64());
        push_event(16'd3, 16'd2, 32'd6);
        push_report(rand64());
        push_event(16'd5, 16'd7, -32'sd1);
        // Removing type 3 leaves two report ends in a row, which collapse.
        filter_type(16'd3);
        push_event(EV_SYN, CODE_DROPPED, 32'd0);
        push_report(rand64());
        // Removing EV_SYN takes the report ends too, so nothing stays committed.
        filter_type(EV_SYN);
        push_report(rand64());
        repeat (2) pop_event();
        wait_drained();
    endtask

    task automatic test_overflow();
        repeat (2) begin
            repeat (QUEUE_DEPTH + 4) push_random_event();
            push_report(rand64());
            repeat (8) pop_event();
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_target);
        int start;
        int pick;
        start = n_items;
        while (n_items - start < n_target) begin
            quiet = (n_items - start >= n_target / 3) && (n_items - start < n_target / 2);
            pick = $urandom_range(99);
            if (pick < 55) begin
                repeat ($urandom_range(1, 6)) push_random_event();
                push_report(rand64());
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 12)) pop_event();
            end else if (pick < 86) begin
                filter_type(pick_type());
            end else if (pick < 88) begin
                wait_drained();
            end else begin
                send_request(t_mode'(2'($urandom_range(3))), 16'($urandom), 16'($urandom),
                             $urandom, rand64());
            end
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    function automatic void check_field(input string name, input logic [63:0] want, got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            n_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_ev_result want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    n_mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("out_valid", 64'(want.vld), 64'(rsp_ch.out_valid));
                    check_field("out_type", 64'(want.typ), 64'(rsp_ch.out_type));
                    check_field("out_code", 64'(want.code), 64'(rsp_ch.out_code));
                    check_field("out_value", {32'd0, want.value},
                                {32'd0, rsp_ch.out_value});
                    check_field("out_stamp", want.stamp, rsp_ch.out_stamp);
                    check_field("queue_empty", 64'(want.empty), 64'(rsp_ch.queue_empty));
                    check_field("overflowed", 64'(want.ovf), 64'(rsp_ch.overflowed));
                end
            end
            rsp_ch.ready <= quiet || ($urandom_range(99) >= 7);
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.mode     <= MODE_NOP;
        req_ch.ev_type  <= '0;
        req_ch.ev_code  <= '0;
        req_ch.ev_value <= '0;
        req_ch.stamp    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_nop();
        test_report_commit();
        test_filter();
        test_overflow();
        test_random_traffic(520);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests in %0d cycles: %0d events popped, %0d reports committed.",
                 n_items, n_cycles, n_popped, n_reports);
        $display("Queue overflows: %0d, filter passes: %0d, mismatches: %0d.",
                 n_overflows, n_filters, n_mismatches);
        if (n_mismatches == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== input_event_queue_with_report_commit_unit.f =====
hdl/ieqrc_pkg.sv
hdl/ieqrc_in_if.sv
hdl/ieqrc_out_if.sv
hdl/ieqrc_ctrl.sv
hdl/ieqrc_dp.sv
hdl/input_event_queue_with_report_commit_unit.sv
tb/sv/tb.sv
